[rtl/dotted_quad_ipv4_parser_top_assert.svh]
// Assertion macros for the dotted quad IPv4 parser.
`ifndef DOTTED_QUAD_IPV4_PARSER_TOP_ASSERT_SVH
`define DOTTED_QUAD_IPV4_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DQIP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define DQIP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DQIP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define DQIP_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/dqip_pkg.sv]
// Shared types and constants for the dotted quad IPv4 parser.
package dqip_pkg;

   localparam logic ACTION_CHAR = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [31:0] SEG_LIMIT  = 32'd256;
   localparam logic [2:0]  SEG_WANTED = 3'd4;
   localparam logic [2:0]  COUNT_SAT  = 3'd5;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BYTE_OVF = 3'd1,
      ST_WRAP     = 3'd2,
      ST_BAD_CHAR = 3'd3,
      ST_COUNT    = 3'd4
   } status_type;

   typedef struct packed {
      logic       action;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic [31:0] address;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } stage_type;

endpackage

[rtl/dqip_req_reg.sv]
// Input register stage for requests.
module dqip_req_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dqip_pkg::req_type req_payload,
   input  logic             take,
   output dqip_pkg::stage_type stage
);
   import dqip_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;
   logic    load;

   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_payload;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

[rtl/dqip_core.sv]
// Segment parsing state and per-character update logic.
`include "dotted_quad_ipv4_parser_top_assert.svh"
module dqip_core (
   input  logic                clock,
   input  logic                reset,
   input  dqip_pkg::stage_type stage,
   input  logic                out_ready,
   output logic                take,
   output logic                res_load,
   output dqip_pkg::rsp_type   result
);
   import dqip_pkg::*;

   logic [31:0] seg_value_ff, seg_value_in;
   logic        seg_has_ff, seg_has_in;
   logic [2:0]  seg_count_ff, seg_count_in;
   logic [31:0] acc_ff, acc_in;
   status_type  err_ff, err_in;

   logic        is_end;
   logic [3:0]  digit;
   logic [35:0] prod;
   status_type  close_err;
   logic [31:0] close_acc;
   logic [2:0]  close_count;
   status_type  end_err;

   assign is_end   = (stage.item.action == ACTION_END);
   assign take     = stage.valid && (!is_end || out_ready);
   assign res_load = take && is_end;

   assign digit = 4'(stage.item.character - CHAR_ZERO);
   assign prod  = ({4'b0, seg_value_ff} << 3) + ({4'b0, seg_value_ff} << 1)
                + {32'b0, digit};

   // closing the open segment
   always_comb begin
      close_err   = err_ff;
      close_acc   = acc_ff;
      close_count = seg_count_ff;
      if (seg_has_ff) begin
         if (seg_value_ff >= SEG_LIMIT) begin
            close_err = ST_BYTE_OVF;
         end else begin
            close_acc = {acc_ff[23:0], seg_value_ff[7:0]};
            if (seg_count_ff < COUNT_SAT) begin
               close_count = seg_count_ff + 3'd1;
            end
         end
      end
   end

   always_comb begin
      end_err = err_ff;
      if (err_ff == ST_OK) begin
         end_err = close_err;
         if (close_err == ST_OK && close_count != SEG_WANTED) begin
            end_err = ST_COUNT;
         end
      end
   end

   assign result.status  = end_err;
   assign result.address = (end_err == ST_OK) ? close_acc : 32'd0;

   always_comb begin
      seg_value_in = seg_value_ff;
      seg_has_in   = seg_has_ff;
      seg_count_in = seg_count_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      if (take) begin
         if (is_end) begin
            seg_value_in = 32'd0;
            seg_has_in   = 1'b0;
            seg_count_in = 3'd0;
            acc_in       = 32'd0;
            err_in       = ST_OK;
         end else if (err_ff == ST_OK) begin
            if (stage.item.character inside {CHAR_SPACE, CHAR_DOT}) begin
               seg_value_in = 32'd0;
               seg_has_in   = 1'b0;
               seg_count_in = close_count;
               acc_in       = close_acc;
               err_in       = close_err;
            end else if (stage.item.character inside {[CHAR_ZERO:CHAR_NINE]}) begin
               if (|prod[35:32]) begin
                  err_in = ST_WRAP;
               end else begin
                  seg_value_in = prod[31:0];
                  seg_has_in   = 1'b1;
               end
            end else begin
               err_in = ST_BAD_CHAR;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_value_ff <= 32'd0;
         seg_has_ff   <= 1'b0;
         seg_count_ff <= 3'd0;
         acc_ff       <= 32'd0;
         err_ff       <= ST_OK;
      end else begin
         seg_value_ff <= seg_value_in;
         seg_has_ff   <= seg_has_in;
         seg_count_ff <= seg_count_in;
         acc_ff       <= acc_in;
         err_ff       <= err_in;
      end
   end

   `DQIP_ASSERT_IMP(a_err_zero_addr, clock, reset, res_load, (result.status == ST_OK || result.address == 32'd0), "error result carries nonzero address")
   `DQIP_ASSERT_NXT(a_end_clears, clock, reset, res_load, (seg_count_ff == 3'd0 && err_ff == ST_OK && !seg_has_ff && acc_ff == 32'd0), "state not cleared after end request")
   `DQIP_ASSERT_NXT(a_err_sticky, clock, reset, (err_ff != ST_OK && !res_load), (err_ff == $past(err_ff)), "first error overwritten")

endmodule

[rtl/dqip_rsp_reg.sv]
// Result register with stall handling.
module dqip_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              res_load,
   input  dqip_pkg::rsp_type result,
   output logic              out_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dqip_pkg::rsp_type rsp_payload
);
   import dqip_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (res_load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

[rtl/dotted_quad_ipv4_parser_top.sv]
// Dotted quad IPv4 parser: one character per request, one result per end request.
// Throughput: one request per cycle; an end request waits only while a result is stalled.
// An accepted end request is held in the input register, and its result is then loaded into the result register.
// The path is input register, one pass of segment update logic, result register.
// Reset (synchronous, active high) clears all parsing state and both valid bits.
module dotted_quad_ipv4_parser_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dqip_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dqip_pkg::rsp_type rsp_payload
);
   import dqip_pkg::*;

   stage_type stage;
   logic      take;
   logic      out_ready;
   logic      res_load;
   rsp_type   result;

   dqip_req_reg u_req_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .take        (take),
      .stage       (stage)
   );

   dqip_core u_core (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .out_ready (out_ready),
      .take      (take),
      .res_load  (res_load),
      .result    (result)
   );

   dqip_rsp_reg u_rsp_reg (
      .clock       (clock),
      .reset       (reset),
      .res_load    (res_load),
      .result      (result),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
